>>> sv/pidsc_pkg.sv
package pidsc_pkg;

    // Field and state widths.
    localparam int SETPOINT_W = 14;
    localparam int SPEED_W    = 16;
    localparam int GAIN_W     = 24;
    localparam int WEIGHT_W   = 17;
    localparam int LIMIT_W    = 16;
    localparam int ERR_W      = 17;
    localparam int DERR_W     = 18;
    localparam int STATE_W    = 48;
    localparam int DIFF_W     = 44;
    localparam int HALF_W     = 22;
    localparam int SUM_W      = 50;
    localparam int WPROD_W    = 62;
    localparam int MUL_A_W    = 25;
    localparam int MUL_B_W    = 23;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int WEIGHT_BITS = 16;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [STATE_W-1:0] t_acc48;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [PROD_W-1:0]  t_prod;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KB    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 3'd6;

    // Register values after reset.
    localparam logic [GAIN_W-1:0]          KP_RESET    = 24'd32768;
    localparam logic [GAIN_W-1:0]          KI_RESET    = 24'd295;
    localparam logic [GAIN_W-1:0]          KD_RESET    = 24'd0;
    localparam logic [GAIN_W-1:0]          KB_RESET    = 24'd328;
    localparam logic [WEIGHT_W-1:0]        FW_RESET    = 17'd58982;
    localparam logic signed [LIMIT_W-1:0]  UPPER_RESET = 16'sd100;
    localparam logic signed [LIMIT_W-1:0]  LOWER_RESET = 16'sd0;

    // Filter weight of exactly one.
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

    // Saturation bounds, held at the width of the sum path.
    localparam t_sum SUM_MAX48 = $signed({3'b000, {47{1'b1}}});
    localparam t_sum SUM_MIN48 = $signed({3'b111, {47{1'b0}}});
    localparam t_sum SUM_MAX16 = $signed({{35{1'b0}}, {15{1'b1}}});
    localparam t_sum SUM_MIN16 = $signed({{35{1'b1}}, {15{1'b0}}});

endpackage

>>> sv/pid_speed_controller.sv
// PID speed controller with a low-pass filtered derivative and back-calculation
// anti-windup. Each input transaction carries a setpoint and a measured speed and
// produces one output transaction with the clamped drive value and two flags that
// tell whether the upper or the lower limit was hit. All six products (P, D, two
// halves of the derivative filter, I and back-calculation) run through a single
// 25x23 signed multiplier under a small sequencer, so a transaction passes through
// an accept state, the multiplier states with the accumulation overlapped, the
// summing states ST_SUM and ST_ISUM, a truncate and saturate stage and a clamp
// stage that loads the output register. The input is not ready while the
// sequencer runs. A finished result sits in an output register, and the next
// input is accepted while it waits; the final stage holds only if an earlier
// result is still not taken. Arithmetic is signed fixed point with FRACTION_BITS
// fraction bits; gain registers are unsigned with the same format and the filter
// weight is Q1.16, where values above one act as one.
module pid_speed_controller
    import pidsc_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Fields from bit 0: setpoint[13:0], measured_speed[29:14], zero padding.
    input  logic [31:0]          s_axis_tdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0: drive[15:0].
    output logic [15:0]          m_axis_tdata,
    // Fields from bit 0: hit_upper[0], hit_lower[1].
    output logic [1:0]           m_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DMUL = 4'd1;
    localparam logic [3:0] ST_PMUL = 4'd2;
    localparam logic [3:0] ST_WLO  = 4'd3;
    localparam logic [3:0] ST_WHI  = 4'd4;
    localparam logic [3:0] ST_IMUL = 4'd5;
    localparam logic [3:0] ST_BMUL = 4'd6;
    localparam logic [3:0] ST_SUM  = 4'd7;
    localparam logic [3:0] ST_ISUM = 4'd8;
    localparam logic [3:0] ST_TRNC = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    localparam t_sum TRUNC_BIAS = $signed((SUM_W'(1) << FRACTION_BITS) - SUM_W'(1));

    // Configuration registers.
    logic [GAIN_W-1:0]         r_kp;
    logic [GAIN_W-1:0]         r_ki;
    logic [GAIN_W-1:0]         r_kd;
    logic [GAIN_W-1:0]         r_kb;
    logic [WEIGHT_W-1:0]       r_fw;
    logic signed [LIMIT_W-1:0] r_upper;
    logic signed [LIMIT_W-1:0] r_lower;

    // Controller state carried between transactions.
    logic signed [ERR_W-1:0]   r_prev_err;
    t_acc48                    r_fd;
    t_acc48                    r_integ;
    logic signed [ERR_W-1:0]   r_exc;

    // Working registers of the sequencer.
    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [DERR_W-1:0]  r_derr;
    t_prod                     r_prod;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [WPROD_W-1:0] r_wprod;
    t_sum                      r_sum;
    t_sum                      r_itmp;
    logic signed [LIMIT_W-1:0] r_u;

    // Output register.
    logic                      r_out_valid;
    logic signed [LIMIT_W-1:0] r_drive;
    logic                      r_hit_upper;
    logic                      r_hit_lower;

    logic                        w_accept;
    logic                        w_out_go;
    logic signed [ERR_W-1:0]     w_err;
    logic signed [DERR_W-1:0]    w_derr;
    logic [WEIGHT_W-1:0]         w_weight;
    logic signed [MUL_A_W-1:0]   w_mul_a;
    logic signed [MUL_B_W-1:0]   w_mul_b;
    t_prod                       w_mul_p;
    t_acc48                      w_dsub;
    logic signed [WPROD_W-1:0]   w_wshift;
    t_acc48                      w_wterm;
    t_sum                        w_prod_ext;
    t_sum                        w_inext;
    t_sum                        w_biased;
    t_sum                        w_quot;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_out_go      = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);

    // Error and error change from the incoming transaction.
    assign w_err  = $signed({3'b000, s_axis_tdata[SETPOINT_W-1:0]})
                  - $signed({s_axis_tdata[29], s_axis_tdata[29:14]});
    assign w_derr = {w_err[ERR_W-1], w_err} - {r_prev_err[ERR_W-1], r_prev_err};

    assign w_weight = (r_fw > WEIGHT_ONE) ? WEIGHT_ONE : r_fw;

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_state)
            ST_DMUL: begin
                w_mul_a = $signed({1'b0, r_kd});
                w_mul_b = $signed({{(MUL_B_W-DERR_W){r_derr[DERR_W-1]}}, r_derr});
            end
            ST_PMUL: begin
                w_mul_a = $signed({1'b0, r_kp});
                w_mul_b = $signed({{(MUL_B_W-ERR_W){r_err[ERR_W-1]}}, r_err});
            end
            ST_WLO: begin
                w_mul_a = $signed({{(MUL_A_W-WEIGHT_W){1'b0}}, w_weight});
                w_mul_b = $signed({1'b0, r_diff[HALF_W-1:0]});
            end
            ST_WHI: begin
                w_mul_a = $signed({{(MUL_A_W-WEIGHT_W){1'b0}}, w_weight});
                w_mul_b = $signed({r_diff[DIFF_W-1], r_diff[DIFF_W-1:HALF_W]});
            end
            ST_IMUL: begin
                w_mul_a = $signed({1'b0, r_ki});
                w_mul_b = $signed({{(MUL_B_W-ERR_W){r_err[ERR_W-1]}}, r_err});
            end
            ST_BMUL: begin
                w_mul_a = $signed({1'b0, r_kb});
                w_mul_b = $signed({{(MUL_B_W-ERR_W){r_exc[ERR_W-1]}}, r_exc});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // Datapath helpers for the accumulation steps.
    assign w_dsub     = r_prod - r_fd;
    assign w_wshift   = r_wprod >>> WEIGHT_BITS;
    assign w_wterm    = w_wshift[STATE_W-1:0];
    assign w_prod_ext = {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_inext    = r_itmp + w_prod_ext;
    assign w_biased   = r_sum + (r_sum[SUM_W-1] ? TRUNC_BIAS : '0);
    assign w_quot     = w_biased >>> FRACTION_BITS;

    // Sequencer.
    always_comb begin
        case (r_state)
            ST_IDLE: n_state = w_accept ? ST_DMUL : ST_IDLE;
            ST_DMUL: n_state = ST_PMUL;
            ST_PMUL: n_state = ST_WLO;
            ST_WLO:  n_state = ST_WHI;
            ST_WHI:  n_state = ST_IMUL;
            ST_IMUL: n_state = ST_BMUL;
            ST_BMUL: n_state = ST_SUM;
            ST_SUM:  n_state = ST_ISUM;
            ST_ISUM: n_state = ST_TRNC;
            ST_TRNC: n_state = ST_OUT;
            ST_OUT:  n_state = w_out_go ? ST_IDLE : ST_OUT;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= KP_RESET;
            r_ki    <= KI_RESET;
            r_kd    <= KD_RESET;
            r_kb    <= KB_RESET;
            r_fw    <= FW_RESET;
            r_upper <= UPPER_RESET;
            r_lower <= LOWER_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KP:    r_kp    <= i_cfg_data;
                REG_KI:    r_ki    <= i_cfg_data;
                REG_KD:    r_kd    <= i_cfg_data;
                REG_KB:    r_kb    <= i_cfg_data;
                REG_FW:    r_fw    <= i_cfg_data[WEIGHT_W-1:0];
                REG_UPPER: r_upper <= $signed(i_cfg_data[LIMIT_W-1:0]);
                REG_LOWER: r_lower <= $signed(i_cfg_data[LIMIT_W-1:0]);
                default: ;
            endcase
        end
    end

    // Controller state, updated as the sequence goes along.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_fd       <= '0;
            r_integ    <= '0;
            r_exc      <= '0;
        end else begin
            if (w_accept) begin
                r_prev_err <= w_err;
            end
            if (r_state == ST_BMUL) begin
                r_fd <= r_fd + w_wterm;
            end
            if (r_state == ST_SUM) begin
                if (w_inext > SUM_MAX48) begin
                    r_integ <= SUM_MAX48[STATE_W-1:0];
                end else if (w_inext < SUM_MIN48) begin
                    r_integ <= SUM_MIN48[STATE_W-1:0];
                end else begin
                    r_integ <= w_inext[STATE_W-1:0];
                end
            end
            if (w_out_go) begin
                if (r_u > r_upper) begin
                    r_exc <= {r_upper[LIMIT_W-1], r_upper} - {r_u[LIMIT_W-1], r_u};
                end else if (r_u < r_lower) begin
                    r_exc <= {r_lower[LIMIT_W-1], r_lower} - {r_u[LIMIT_W-1], r_u};
                end else begin
                    r_exc <= '0;
                end
            end
        end
    end

    // Working registers: product capture and the accumulation steps.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_p;
        case (r_state)
            ST_IDLE: begin
                r_err  <= w_err;
                r_derr <= w_derr;
            end
            ST_PMUL: r_diff <= w_dsub[DIFF_W-1:0];
            ST_WLO:  r_sum  <= w_prod_ext;
            ST_WHI:  r_wprod <= {{(WPROD_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            ST_IMUL: r_wprod <= r_wprod
                              + ({{(WPROD_W-PROD_W){r_prod[PROD_W-1]}}, r_prod} <<< HALF_W);
            ST_BMUL: r_itmp <= {{(SUM_W-STATE_W){r_integ[STATE_W-1]}}, r_integ} + w_prod_ext;
            ST_SUM:  r_sum  <= r_sum + {{(SUM_W-STATE_W){r_fd[STATE_W-1]}}, r_fd};
            // The integral is registered at the end of ST_SUM, so it joins the sum here in ST_ISUM.
            ST_ISUM: r_sum  <= r_sum + {{(SUM_W-STATE_W){r_integ[STATE_W-1]}}, r_integ};
            ST_TRNC: begin
                if (w_quot > SUM_MAX16) begin
                    r_u <= SUM_MAX16[LIMIT_W-1:0];
                end else if (w_quot < SUM_MIN16) begin
                    r_u <= SUM_MIN16[LIMIT_W-1:0];
                end else begin
                    r_u <= w_quot[LIMIT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // Output register and its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_go) begin
            if (r_u > r_upper) begin
                r_drive     <= r_upper;
                r_hit_upper <= 1'b1;
                r_hit_lower <= 1'b0;
            end else if (r_u < r_lower) begin
                r_drive     <= r_lower;
                r_hit_upper <= 1'b0;
                r_hit_lower <= 1'b1;
            end else begin
                r_drive     <= r_u;
                r_hit_upper <= 1'b0;
                r_hit_lower <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_drive;
    assign m_axis_tuser  = {r_hit_lower, r_hit_upper};

    // At most one limit flag is raised on a result.
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("both limit flags set on one result");

    // A result flagged at the upper limit carries that limit.
    a_upper_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == r_upper))
        else $error("upper flag without upper limit on drive");

    // An accepted transaction keeps the input closed in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("input ready while a transaction is in progress");

    // A new result is loaded only when the output register is free or being emptied.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("pending result overwritten");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pidsc_pkg::*;

    localparam int FRAC_BITS      = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 30;

    // Index outside the register map; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    localparam longint ACC_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN   = -ACC_MAX - 1;
    localparam longint DRIVE_MAX = 32767;
    localparam longint DRIVE_MIN = -32768;

    typedef struct packed {
        logic signed [LIMIT_W-1:0] drive;
        logic                      hit_upper;
        logic                      hit_lower;
    } t_drive_result;

    // Predicts the drive for each accepted speed sample and checks the results.
    class drive_scoreboard;
        longint                    kp, ki, kd, kb;
        logic [WEIGHT_W-1:0]       weight;
        logic signed [LIMIT_W-1:0] upper, lower;
        longint                    prev_err, filt_deriv, integ, excess;
        t_drive_result             expected_drives[$];
        int                        mismatches;

        function new();
            kp = KP_RESET;
            ki = KI_RESET;
            kd = KD_RESET;
            kb = KB_RESET;
            weight = FW_RESET;
            upper = UPPER_RESET;
            lower = LOWER_RESET;
            prev_err = 0;
            filt_deriv = 0;
            integ = 0;
            excess = 0;
            mismatches = 0;
        endfunction

        task report(input string msg);
            mismatches++;
            $display("%0t mismatch: %s", $time, msg);
        endtask

        function void write_register(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [GAIN_W-1:0] val);
            case (idx)
                REG_KP:    kp = longint'(val);
                REG_KI:    ki = longint'(val);
                REG_KD:    kd = longint'(val);
                REG_KB:    kb = longint'(val);
                REG_FW:    weight = val[WEIGHT_W-1:0];
                REG_UPPER: upper = signed'(val[LIMIT_W-1:0]);
                REG_LOWER: lower = signed'(val[LIMIT_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint clip_integral(input longint v);
            if (v > ACC_MAX) return ACC_MAX;
            if (v < ACC_MIN) return ACC_MIN;
            return v;
        endfunction

        function void note_speed_sample(input logic [SETPOINT_W-1:0] sp,
                                        input logic signed [SPEED_W-1:0] meas);
            longint err, w, p, d, df, s, u;
            t_drive_result r;
            err = longint'(sp) - longint'(meas);
            // A weight above one behaves as exactly one.
            w = (weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight);
            p = kp * err;
            d = kd * (err - prev_err);
            df = filt_deriv + ((w * (d - filt_deriv)) >>> WEIGHT_BITS);
            integ = clip_integral(integ + ki * err + kb * excess);
            filt_deriv = df;
            prev_err = err;

            // Truncate toward zero, then saturate to the 16-bit range.
            s = p + df + integ;
            u = (s < 0) ? -((-s) >>> FRAC_BITS) : (s >>> FRAC_BITS);
            if (u > DRIVE_MAX) u = DRIVE_MAX;
            if (u < DRIVE_MIN) u = DRIVE_MIN;

            // The upper test wins when the limits are swapped.
            r.hit_upper = 1'b0;
            r.hit_lower = 1'b0;
            if (u > longint'(upper)) begin
                r.drive = upper;
                excess = longint'(upper) - u;
                r.hit_upper = 1'b1;
            end else if (u < longint'(lower)) begin
                r.drive = lower;
                excess = longint'(lower) - u;
                r.hit_lower = 1'b1;
            end else begin
                r.drive = u[LIMIT_W-1:0];
                excess = 0;
            end
            expected_drives.push_back(r);
        endfunction

        task check_drive(input logic [15:0] data, input logic [1:0] user);
            t_drive_result want;
            if (expected_drives.size() == 0) begin
                report($sformatf("drive %0d arrived with no sample pending", $signed(data)));
                return;
            end
            want = expected_drives.pop_front();
            if (data !== want.drive)
                report($sformatf("drive got %0d expected %0d", $signed(data), want.drive));
            if (user[0] !== want.hit_upper)
                report($sformatf("hit_upper got %b expected %b", user[0], want.hit_upper));
            if (user[1] !== want.hit_lower)
                report($sformatf("hit_lower got %b expected %b", user[1], want.hit_lower));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic [31:0]          s_axis_tdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [GAIN_W-1:0]    i_cfg_data;

    drive_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int holds_served;

    pid_speed_controller #(
        .FRACTION_BITS(FRAC_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one speed sample and return at the falling edge after its transaction.
    // Valid is left high so that back-to-back samples keep it up; idling lowers it.
    task automatic send_sample(input logic [SETPOINT_W-1:0] sp,
                               input logic signed [SPEED_W-1:0] meas);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata = {2'b00, meas, sp};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_speed_sample(sp, meas);
        @(negedge i_clk);
    endtask

    // Stop offering samples and wait until every predicted drive has been taken.
    task automatic wait_for_drives();
        s_axis_tvalid = 1'b0;
        while (sb.expected_drives.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [GAIN_W-1:0] val);
        i_cfg_index = idx;
        i_cfg_data = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain(input int unsigned typical_max);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(0, typical_max));
        endcase
    endfunction

    // New gains, weight and limits; the upper data bits are random so they toggle too.
    task automatic randomize_settings();
        logic [15:0] lim;
        write_setting(REG_KP, pick_gain(32'h20000));
        write_setting(REG_KI, pick_gain(32'h1000));
        write_setting(REG_KD, pick_gain(32'h10000));
        write_setting(REG_KB, pick_gain(32'h4000));
        case ($urandom_range(0, 3))
            0: write_setting(REG_FW, '0);
            1: write_setting(REG_FW, GAIN_W'(WEIGHT_ONE));
            2: write_setting(REG_FW, GAIN_W'($urandom));
            default: write_setting(REG_FW, GAIN_W'($urandom_range(0, 65536)));
        endcase
        case ($urandom_range(0, 3))
            0: begin
                write_setting(REG_UPPER, {8'($urandom), 16'h7FFF});
                write_setting(REG_LOWER, {8'($urandom), 16'h8000});
            end
            1: begin
                write_setting(REG_UPPER, GAIN_W'($urandom));
                write_setting(REG_LOWER, GAIN_W'($urandom));
            end
            default: begin
                lim = 16'($urandom_range(20, 400));
                write_setting(REG_UPPER, {8'($urandom), lim});
                write_setting(REG_LOWER, {8'($urandom), ($urandom_range(0, 1) != 0) ? -lim : 16'h0});
            end
        endcase
        if ($urandom_range(0, 3) == 0)
            write_setting(REG_NONE, GAIN_W'($urandom));
    endtask

    // Mostly a measured speed that tracks a held setpoint, with some random noise.
    task automatic run_tracking(input int count);
        logic [SETPOINT_W-1:0] sp;
        int m;
        sp = SETPOINT_W'($urandom_range(0, 9999));
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 12)
                sp = SETPOINT_W'($urandom_range(0, 9999));
            if ($urandom_range(0, 99) < 15) begin
                send_sample(SETPOINT_W'($urandom), SPEED_W'($urandom));
            end else begin
                m = int'(sp) + int'($urandom_range(0, 600)) - 300;
                send_sample(sp, SPEED_W'(m));
            end
        end
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        holds_served = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Check every result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_drive(m_axis_tdata, m_axis_tuser);
    end

    // End the run when no transaction of any kind happens for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        i_rst_n = 1'b0;
        s_axis_tdata = '0;
        s_axis_tvalid = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        hold_requests = 0;
        send_idle_pct = 8;
        recv_idle_pct = 54;
        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Field extremes under the reset settings.
        send_sample(14'd0, 16'h0000);
        send_sample(14'h3FFF, 16'h8000);
        send_sample(14'd0, 16'h7FFF);
        send_sample(14'd9999, 16'd9999);
        send_sample(14'h3FFF, 16'h7FFF);
        send_sample(14'd0, 16'h8000);
        send_sample(14'd5000, 16'd4900);
        send_sample(14'd5000, 16'd4950);
        wait_for_drives();

        // Maximum proportional, derivative and back-calculation gains, zero integral
        // gain, a filter weight above one, swapped limits and a write to the unused index.
        write_setting(REG_KP, '1);
        write_setting(REG_KI, '0);
        write_setting(REG_KD, '1);
        write_setting(REG_KB, '1);
        write_setting(REG_FW, '1);
        write_setting(REG_UPPER, 24'hFFFFCE);
        write_setting(REG_LOWER, 24'h000032);
        write_setting(REG_NONE, 24'h123456);
        send_sample(14'h3FFF, 16'h8000);
        send_sample(14'd0, 16'h7FFF);
        send_sample(14'd100, 16'd100);
        send_sample(14'd0, 16'h0000);
        send_sample(14'd200, 16'd199);
        wait_for_drives();

        // Moderate gains, zero filter weight and the widest limits.
        write_setting(REG_KP, 24'h010000);
        write_setting(REG_KI, 24'h000100);
        write_setting(REG_KD, 24'h008000);
        write_setting(REG_KB, '0);
        write_setting(REG_FW, '0);
        write_setting(REG_UPPER, 24'h007FFF);
        write_setting(REG_LOWER, 24'hFF8000);
        send_sample(14'd1000, 16'd900);
        send_sample(14'd1000, 16'd1100);
        send_sample(14'd1000, 16'd1000);
        send_sample(14'h3FFF, 16'h8000);
        send_sample(14'd0, 16'h7FFF);
        wait_for_drives();

        // Random settings and tracking runs under each idling pattern.
        for (int g = 0; g < 3; g++) begin
            send_idle_pct = (g == 0) ? 8 : (g == 1) ? 54 : 0;
            recv_idle_pct = (g == 0) ? 54 : (g == 1) ? 8 : 0;
            for (int ph = 0; ph < 5; ph++) begin
                wait_for_drives();
                randomize_settings();
                run_tracking(70);
            end
        end

        // Drive the integral into positive saturation with the largest error,
        // while the receiver holds off long enough to stall the input.
        wait_for_drives();
        write_setting(REG_KP, '0);
        write_setting(REG_KD, '0);
        write_setting(REG_KI, '1);
        write_setting(REG_KB, '1);
        write_setting(REG_UPPER, 24'h007FFF);
        write_setting(REG_LOWER, 24'h007FFF);
        hold_requests++;
        for (int k = 0; k < 250; k++)
            send_sample(14'h3FFF, SPEED_W'(16'h8000 + $urandom_range(0, 15)));

        // Then all the way down into negative saturation.
        wait_for_drives();
        write_setting(REG_UPPER, 24'hFF8000);
        write_setting(REG_LOWER, 24'hFF8000);
        for (int k = 0; k < 400; k++)
            send_sample(SETPOINT_W'($urandom_range(0, 15)), 16'h7FFF);

        wait_for_drives();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
